// ===== design/ptc_pkg.sv =====
// ---------------------------------------------------------------------------
// ptc_pkg: shared types and helpers for the point/triangle contact test
// Word formats, pipeline forwarding record, latencies of the iterative units.
// ---------------------------------------------------------------------------
package ptc_pkg;

    localparam int SQRT_LAT = 32;           // one root bit per stage
    localparam int DIV_LAT  = 31;           // one quotient bit per stage
    localparam logic [15:0] TOL_RESET = 16'd1;

    typedef logic signed [31:0] t_s32;
    typedef logic signed [39:0] t_s40;

    typedef struct packed {
        t_s32 point_x;
        t_s32 point_y;
        t_s32 point_z;
        t_s32 vertex_a_x;
        t_s32 vertex_a_y;
        t_s32 vertex_a_z;
        t_s32 vertex_b_x;
        t_s32 vertex_b_y;
        t_s32 vertex_b_z;
        t_s32 vertex_c_x;
        t_s32 vertex_c_y;
        t_s32 vertex_c_z;
    } t_in_word;

    typedef struct packed {
        t_s32 normal_x;
        t_s32 normal_y;
        t_s32 normal_z;
        t_s32 gap_value;
        t_s32 projected_x;
        t_s32 projected_y;
        t_s32 projected_z;
        logic inside_flag;
        logic in_area_flag;
        logic degenerate_flag;
    } t_out_word;

    // values that ride along the pipeline; each field is filled at its stage
    typedef struct packed {
        t_s32 [2:0]        p;
        t_s32 [2:0]        va;
        t_s32 [2:0]        vb;
        t_s32 [2:0]        vc;
        logic [2:0][29:0]  mn;
        logic [2:0]        sgn;
        logic              deg;
        t_s32 [2:0]        nv;
        logic signed [35:0] g;
        logic              below;
        t_s40 [2:0]        q;
        logic [3:0]        s;
        logic [3:0][4:0]   k;
        logic              in_area;
    } t_fwd;

    function automatic logic [63:0] f_abs(input logic signed [63:0] x);
        return x[63] ? 64'(-x) : 64'(x);
    endfunction

    function automatic logic [5:0] f_msb(input logic [63:0] x);
        logic [5:0] r;
        r = '0;
        for (int b = 0; b < 64; b++) begin
            if (x[b]) r = 6'(b);
        end
        return r;
    endfunction

    function automatic t_s32 f_sat(input logic signed [63:0] x);
        if (x > 64'sd2147483647) return 32'sh7fffffff;
        else if (x < -64'sd2147483648) return 32'sh80000000;
        else return x[31:0];
    endfunction

endpackage

// ===== design/ptc_if.sv =====
// ---------------------------------------------------------------------------
// ptc_if: valid/ready channels of the contact test
// Input channel carries point and vertices, output channel the contact result.
// ---------------------------------------------------------------------------
interface ptc_in_if;
    logic              valid;
    logic              ready;
    ptc_pkg::t_in_word data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface ptc_out_if;
    logic               valid;
    logic               ready;
    ptc_pkg::t_out_word data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// ===== design/ptc_isqrt.sv =====
// ---------------------------------------------------------------------------
// ptc_isqrt: pipelined integer square root
// floor(sqrt(x)) of a 64-bit word, one root bit resolved per stage.
// ---------------------------------------------------------------------------
module ptc_isqrt (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_x,
    output logic [31:0] o_root
);
    localparam int NB = ptc_pkg::SQRT_LAT;

    logic [63:0] r_rem  [NB];
    logic [31:0] r_root [NB];

    for (genvar j = 0; j < NB; j++) begin : g_bit
        localparam int B = NB - 1 - j;
        logic [63:0] rem_in;
        logic [31:0] root_in;
        logic [65:0] trial;

        if (j == 0) begin : g_first
            assign rem_in  = i_x;
            assign root_in = '0;
        end else begin : g_next
            assign rem_in  = r_rem[j-1];
            assign root_in = r_root[j-1];
        end

        // (r + 2^B)^2 - r^2 = r*2^(B+1) + 2^(2B)
        assign trial = (66'(root_in) << (B + 1)) | (66'd1 << (2 * B));

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (66'(rem_in) >= trial) begin
                    r_rem[j]  <= 64'(66'(rem_in) - trial);
                    r_root[j] <= root_in | (32'd1 << B);
                end else begin
                    r_rem[j]  <= rem_in;
                    r_root[j] <= root_in;
                end
            end
        end
    end

    assign o_root = r_root[NB-1];
endmodule

// ===== design/ptc_div.sv =====
// ---------------------------------------------------------------------------
// ptc_div: pipelined restoring divider
// floor(num / den) for a quotient below 2^31, one quotient bit per stage.
// ---------------------------------------------------------------------------
module ptc_div (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [60:0] i_num,
    input  logic [30:0] i_den,
    output logic [30:0] o_quo
);
    localparam int NB = ptc_pkg::DIV_LAT;

    logic [60:0] r_rem [NB];
    logic [30:0] r_den [NB];
    logic [30:0] r_quo [NB];

    for (genvar j = 0; j < NB; j++) begin : g_bit
        localparam int B = NB - 1 - j;
        logic [60:0] rem_in;
        logic [30:0] den_in;
        logic [30:0] quo_in;
        logic [60:0] trial;

        if (j == 0) begin : g_first
            assign rem_in = i_num;
            assign den_in = i_den;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[j-1];
            assign den_in = r_den[j-1];
            assign quo_in = r_quo[j-1];
        end

        assign trial = 61'(den_in) << B;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[j] <= den_in;
                if (rem_in >= trial) begin
                    r_rem[j] <= rem_in - trial;
                    r_quo[j] <= quo_in | (31'd1 << B);
                end else begin
                    r_rem[j] <= rem_in;
                    r_quo[j] <= quo_in;
                end
            end
        end
    end

    assign o_quo = r_quo[NB-1];
endmodule

// ===== design/point_triangle_contact_test.sv =====
// ---------------------------------------------------------------------------
// point_triangle_contact_test: point against triangle contact check
// Unit normal, signed gap, projection on the plane and projection area test.
// ---------------------------------------------------------------------------
// A new word is taken every clock cycle while the output side takes results.
// The pipeline depth is set by the normal square root (32 stages, one root bit
// each), the normal divide (31 stages, one quotient bit each) and the area square
// roots (32 stages); the remaining stages are edge setup, cross products, scaling,
// gap, projection, area sums and the final compare.
// A stall on the output holds the whole pipeline; nothing is dropped.
// ---------------------------------------------------------------------------
module point_triangle_contact_test (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ptc_in_if.sink      i_in,
    ptc_out_if.source   o_out,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data
);
    localparam int ST_MAG  = 5;
    localparam int ST_MN   = 6;
    localparam int ST_SS   = 8;
    localparam int ST_L    = ST_SS + ptc_pkg::SQRT_LAT;
    localparam int ST_Q    = ST_L + ptc_pkg::DIV_LAT;
    localparam int ST_N    = ST_Q + 1;
    localparam int ST_G    = ST_N + 3;
    localparam int ST_QP   = ST_N + 5;
    localparam int ST_SH   = ST_N + 7;
    localparam int ST_XM   = ST_N + 10;
    localparam int ST_XSUM = ST_N + 13;
    localparam int ST_XR   = ST_XSUM + ptc_pkg::SQRT_LAT;
    localparam int ST_NRM  = ST_XR + 1;
    localparam int ST_CMP  = ST_NRM + 1;
    localparam int ST_OUT  = ST_CMP + 1;

    localparam int XA [4] = '{0, 2, 3, 4};
    localparam int XB [4] = '{1, 3, 4, 2};

    logic               w_en;
    logic [ST_OUT:0]    r_vld;
    logic [15:0]        r_tol;
    ptc_pkg::t_fwd      r_f [ST_CMP+1];
    ptc_pkg::t_fwd      n_f [ST_CMP+1];
    ptc_pkg::t_out_word r_out;
    ptc_pkg::t_out_word n_out;

    // stage registers
    logic signed [32:0] r_d [3], r_e [3], n_d [3], n_e [3];
    logic signed [30:0] r_ds [3], r_es [3], n_ds [3], n_es [3];
    logic signed [61:0] r_pr [6], n_pr [6];
    logic signed [62:0] r_cr [3], n_cr [3];
    logic [61:0]        r_m [3], n_m [3];
    logic [5:0]         r_lead, n_lead;
    logic [59:0]        r_sq [3], n_sq [3];
    logic [61:0]        r_ss, n_ss;
    logic signed [62:0] r_gp [3], n_gp [3];
    logic signed [63:0] r_acc, n_acc;
    logic signed [29:0] r_rn [3], n_rn [3];
    logic signed [65:0] r_gr [3], n_gr [3];
    logic signed [40:0] r_w [5][3], n_w [5][3];
    logic signed [30:0] r_ws [5][3], n_ws [5][3];
    logic signed [61:0] r_xp [4][6], n_xp [4][6];
    logic signed [62:0] r_xc [4][3], n_xc [4][3];
    logic [61:0]        r_xm [4][3], n_xm [4][3];
    logic [30:0]        r_xt [4][3], n_xt [4][3];
    logic [61:0]        r_xs [4][3], n_xs [4][3];
    logic [63:0]        r_xsum [4], n_xsum [4];
    logic [63:0]        r_nrm [4], n_nrm [4];

    logic [31:0]        w_len_root;
    logic [30:0]        w_len;
    logic [60:0]        w_num [3];
    logic [30:0]        w_quo [3];
    logic [31:0]        w_xroot [4];

    logic signed [35:0] g_val;
    logic               g_ins;
    logic signed [39:0] q_val [3];
    logic [3:0]         sh_s;
    logic [4:0]         xm_k [4];
    logic               cmp_in;

    assign w_en        = ~r_vld[ST_OUT] | o_out.ready;
    assign i_in.ready  = w_en;
    assign o_out.valid = r_vld[ST_OUT];
    assign o_out.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_tol <= ptc_pkg::TOL_RESET;
        end else begin
            if (i_cfg_we) r_tol <= i_cfg_data;
            if (w_en) r_vld <= {r_vld[ST_OUT-1:0], i_in.valid};
        end
    end

    // ---------------- forwarding record ----------------
    always_comb begin
        n_f[0]       = r_f[0];
        n_f[0].p[0]  = i_in.data.point_x;
        n_f[0].p[1]  = i_in.data.point_y;
        n_f[0].p[2]  = i_in.data.point_z;
        n_f[0].va[0] = i_in.data.vertex_a_x;
        n_f[0].va[1] = i_in.data.vertex_a_y;
        n_f[0].va[2] = i_in.data.vertex_a_z;
        n_f[0].vb[0] = i_in.data.vertex_b_x;
        n_f[0].vb[1] = i_in.data.vertex_b_y;
        n_f[0].vb[2] = i_in.data.vertex_b_z;
        n_f[0].vc[0] = i_in.data.vertex_c_x;
        n_f[0].vc[1] = i_in.data.vertex_c_y;
        n_f[0].vc[2] = i_in.data.vertex_c_z;
        for (int k = 1; k <= ST_CMP; k++) n_f[k] = r_f[k-1];
        n_f[ST_MAG].deg = (r_cr[0] == '0) && (r_cr[1] == '0) && (r_cr[2] == '0);
        for (int i = 0; i < 3; i++) begin
            n_f[ST_MAG].sgn[i] = r_cr[i][62];
            n_f[ST_MN].mn[i]   = (r_lead >= 6'd30) ? 30'(r_m[i] >> (r_lead - 6'd29))
                                                   : 30'(r_m[i] << (6'd29 - r_lead));
            n_f[ST_N].nv[i]    = r_f[ST_Q].sgn[i] ? -32'(w_quo[i]) : 32'(w_quo[i]);
        end
        n_f[ST_G].g     = g_val;
        n_f[ST_G].below = g_ins;
        for (int i = 0; i < 3; i++) n_f[ST_QP].q[i] = q_val[i];
        n_f[ST_SH].s = sh_s;
        for (int v = 0; v < 4; v++) n_f[ST_XM].k[v] = xm_k[v];
        n_f[ST_CMP].in_area = cmp_in;
    end

    // ---------------- normal: edges, cross product ----------------
    logic [63:0] e_or;
    logic [5:0]  e_msb;
    logic [1:0]  e_sn;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_d[i] = 33'($signed(r_f[0].vb[i])) - 33'($signed(r_f[0].va[i]));
            n_e[i] = 33'($signed(r_f[0].vc[i])) - 33'($signed(r_f[0].va[i]));
        end
        e_or = '0;
        for (int i = 0; i < 3; i++) begin
            e_or = e_or | ptc_pkg::f_abs(64'(r_d[i])) | ptc_pkg::f_abs(64'(r_e[i]));
        end
        e_msb = ptc_pkg::f_msb(e_or);
        e_sn  = (e_msb >= 6'd30) ? 2'(e_msb - 6'd29) : 2'd0;
        for (int i = 0; i < 3; i++) begin
            n_ds[i] = 31'(r_d[i] >>> e_sn);
            n_es[i] = 31'(r_e[i] >>> e_sn);
        end
        n_pr[0] = r_ds[1] * r_es[2];
        n_pr[1] = r_ds[2] * r_es[1];
        n_pr[2] = r_ds[2] * r_es[0];
        n_pr[3] = r_ds[0] * r_es[2];
        n_pr[4] = r_ds[0] * r_es[1];
        n_pr[5] = r_ds[1] * r_es[0];
        for (int i = 0; i < 3; i++) n_cr[i] = 63'(r_pr[2*i]) - 63'(r_pr[2*i+1]);
    end

    // ---------------- normal: magnitude, length ----------------
    logic [63:0] m_or;
    always_comb begin
        m_or = '0;
        for (int i = 0; i < 3; i++) begin
            n_m[i] = 62'(ptc_pkg::f_abs(64'(r_cr[i])));
            m_or   = m_or | ptc_pkg::f_abs(64'(r_cr[i]));
        end
        n_lead = ptc_pkg::f_msb(m_or);
        for (int i = 0; i < 3; i++) n_sq[i] = r_f[ST_MN].mn[i] * r_f[ST_MN].mn[i];
        n_ss = 62'(r_sq[0]) + 62'(r_sq[1]) + 62'(r_sq[2]);
    end

    ptc_isqrt u_len_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_x    (64'(r_ss)),
        .o_root (w_len_root)
    );

    assign w_len = w_len_root[30:0];

    for (genvar i = 0; i < 3; i++) begin : g_ndiv
        // round to nearest: add half the divisor
        assign w_num[i] = {1'b0, r_f[ST_L].mn[i], 30'd0} + 61'(w_len[30:1]);
        ptc_div u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (w_num[i]),
            .i_den (w_len),
            .o_quo (w_quo[i])
        );
    end

    // ---------------- gap and projection ----------------
    logic signed [32:0] gp_pa;
    logic signed [64:0] gp_prod;
    logic signed [63:0] g_rnd;
    logic signed [36:0] g_cmp;
    logic signed [32:0] rn_rnd;
    logic signed [65:0] q_rnd;
    logic signed [37:0] q_corr;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            gp_pa   = 33'($signed(r_f[ST_N].p[i])) - 33'($signed(r_f[ST_N].va[i]));
            gp_prod = gp_pa * $signed(r_f[ST_N].nv[i]);
            n_gp[i] = 63'(gp_prod >>> 2);
        end
        n_acc = 64'(r_gp[0]) + 64'(r_gp[1]) + 64'(r_gp[2]);
        g_rnd = r_acc + 64'sd134217728;
        g_val = 36'(g_rnd >>> 28);
        g_cmp = 37'(g_val) + 37'($signed({1'b0, r_tol}));
        g_ins = g_cmp[36];
        for (int i = 0; i < 3; i++) begin
            rn_rnd  = 33'($signed(r_f[ST_G-1].nv[i])) + 33'sd2;
            n_rn[i] = 30'(rn_rnd >>> 2);
            n_gr[i] = $signed(r_f[ST_G].g) * r_rn[i];
        end
        for (int i = 0; i < 3; i++) begin
            q_rnd    = r_gr[i] + 66'sd134217728;
            q_corr   = 38'(q_rnd >>> 28);
            q_val[i] = 40'($signed(r_f[ST_QP-1].p[i])) - 40'(q_corr);
        end
    end

    // ---------------- area test ----------------
    logic [63:0] sh_or;
    logic [5:0]  sh_msb;
    logic [63:0] xm_or;
    logic [5:0]  xm_msb;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_w[0][i] = 41'($signed(r_f[ST_QP].vb[i])) - 41'($signed(r_f[ST_QP].va[i]));
            n_w[1][i] = 41'($signed(r_f[ST_QP].vc[i])) - 41'($signed(r_f[ST_QP].va[i]));
            n_w[2][i] = 41'($signed(r_f[ST_QP].va[i])) - 41'($signed(r_f[ST_QP].q[i]));
            n_w[3][i] = 41'($signed(r_f[ST_QP].vb[i])) - 41'($signed(r_f[ST_QP].q[i]));
            n_w[4][i] = 41'($signed(r_f[ST_QP].vc[i])) - 41'($signed(r_f[ST_QP].q[i]));
        end
        sh_or = '0;
        for (int j = 0; j < 5; j++) begin
            for (int i = 0; i < 3; i++) sh_or = sh_or | ptc_pkg::f_abs(64'(r_w[j][i]));
        end
        sh_msb = ptc_pkg::f_msb(sh_or);
        sh_s   = (sh_msb >= 6'd30) ? 4'(sh_msb - 6'd29) : 4'd0;
        for (int j = 0; j < 5; j++) begin
            for (int i = 0; i < 3; i++) n_ws[j][i] = 31'(r_w[j][i] >>> sh_s);
        end
        for (int v = 0; v < 4; v++) begin
            n_xp[v][0] = r_ws[XA[v]][1] * r_ws[XB[v]][2];
            n_xp[v][1] = r_ws[XA[v]][2] * r_ws[XB[v]][1];
            n_xp[v][2] = r_ws[XA[v]][2] * r_ws[XB[v]][0];
            n_xp[v][3] = r_ws[XA[v]][0] * r_ws[XB[v]][2];
            n_xp[v][4] = r_ws[XA[v]][0] * r_ws[XB[v]][1];
            n_xp[v][5] = r_ws[XA[v]][1] * r_ws[XB[v]][0];
            for (int i = 0; i < 3; i++) n_xc[v][i] = 63'(r_xp[v][2*i]) - 63'(r_xp[v][2*i+1]);
        end
        for (int v = 0; v < 4; v++) begin
            xm_or = '0;
            for (int i = 0; i < 3; i++) begin
                n_xm[v][i] = 62'(ptc_pkg::f_abs(64'(r_xc[v][i])));
                xm_or      = xm_or | ptc_pkg::f_abs(64'(r_xc[v][i]));
            end
            xm_msb  = ptc_pkg::f_msb(xm_or);
            xm_k[v] = (xm_msb >= 6'd31) ? 5'(xm_msb - 6'd30) : 5'd0;
            for (int i = 0; i < 3; i++) begin
                n_xt[v][i] = 31'(r_xm[v][i] >> r_f[ST_XM].k[v]);
                n_xs[v][i] = r_xt[v][i] * r_xt[v][i];
            end
            n_xsum[v] = 64'(r_xs[v][0]) + 64'(r_xs[v][1]) + 64'(r_xs[v][2]);
            n_nrm[v]  = 64'(w_xroot[v]) << r_f[ST_XR].k[v];
        end
    end

    for (genvar v = 0; v < 4; v++) begin : g_xsqrt
        ptc_isqrt u_sqrt (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_x    (r_xsum[v]),
            .o_root (w_xroot[v])
        );
    end

    logic [65:0] cmp_sub;
    logic [32:0] cmp_thr;
    always_comb begin
        cmp_sub = 66'(r_nrm[1]) + 66'(r_nrm[2]) + 66'(r_nrm[3]);
        // slack in area LSBs, scaled down with the shared vector shift
        cmp_thr = {r_tol, 17'd0} >> {r_f[ST_NRM].s, 1'b0};
        cmp_in  = cmp_sub <= (66'(r_nrm[0]) + 66'(cmp_thr));
    end

    // ---------------- result word ----------------
    always_comb begin
        n_out.normal_x        = r_f[ST_CMP].nv[0];
        n_out.normal_y        = r_f[ST_CMP].nv[1];
        n_out.normal_z        = r_f[ST_CMP].nv[2];
        n_out.gap_value       = ptc_pkg::f_sat(64'($signed(r_f[ST_CMP].g)));
        n_out.projected_x     = ptc_pkg::f_sat(64'($signed(r_f[ST_CMP].q[0])));
        n_out.projected_y     = ptc_pkg::f_sat(64'($signed(r_f[ST_CMP].q[1])));
        n_out.projected_z     = ptc_pkg::f_sat(64'($signed(r_f[ST_CMP].q[2])));
        n_out.inside_flag     = r_f[ST_CMP].below;
        n_out.in_area_flag    = r_f[ST_CMP].in_area;
        n_out.degenerate_flag = 1'b0;
        // zero-area triangle: drop everything but the flag
        if (r_f[ST_CMP].deg) begin
            n_out                 = '0;
            n_out.degenerate_flag = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k <= ST_CMP; k++) r_f[k] <= n_f[k];
            r_out  <= n_out;
            r_d    <= n_d;
            r_e    <= n_e;
            r_ds   <= n_ds;
            r_es   <= n_es;
            r_pr   <= n_pr;
            r_cr   <= n_cr;
            r_m    <= n_m;
            r_lead <= n_lead;
            r_sq   <= n_sq;
            r_ss   <= n_ss;
            r_gp   <= n_gp;
            r_acc  <= n_acc;
            r_rn   <= n_rn;
            r_gr   <= n_gr;
            r_w    <= n_w;
            r_ws   <= n_ws;
            r_xp   <= n_xp;
            r_xc   <= n_xc;
            r_xm   <= n_xm;
            r_xt   <= n_xt;
            r_xs   <= n_xs;
            r_xsum <= n_xsum;
            r_nrm  <= n_nrm;
        end
    end
endmodule

// ===== tb/sv/ptc_checker.sv =====
// ---------------------------------------------------------------------------
// ptc_checker: result predictor and scoreboard for the contact test
// Computes the expected contact result of every accepted input word and
// compares each accepted output word with the oldest expected one.
// ---------------------------------------------------------------------------
module ptc_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  ptc_pkg::t_in_word  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  ptc_pkg::t_out_word i_out_data,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_result_count,
    output int                 o_deg_count,
    output int                 o_area_count,
    output int                 o_inside_count
);

    ptc_pkg::t_out_word contact_q[$];
    logic [15:0]        tol_reg;

    function automatic longint mag64(input longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint floor_shr(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint round_shr(input longint v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint sat_word(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic int fit_shift_of(input longint v[15], input int n);
        int s;
        s = 0;
        for (int i = 0; i < n; i++)
            while ((mag64(v[i]) >> s) >= 64'sd1073741824) s++;
        return s;
    endfunction

    function automatic logic [63:0] cross_norm(input longint a[3], input longint b[3]);
        longint      c[3];
        logic [63:0] m[3];
        logic [63:0] sum;
        int          k;
        c[0] = a[1] * b[2] - a[2] * b[1];
        c[1] = a[2] * b[0] - a[0] * b[2];
        c[2] = a[0] * b[1] - a[1] * b[0];
        k = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = mag64(c[i]);
            while ((m[i] >> k) >= 64'd2147483648) k++;
        end
        sum = 0;
        for (int i = 0; i < 3; i++) sum += (m[i] >> k) * (m[i] >> k);
        return int_sqrt(sum) << k;
    endfunction

    function automatic ptc_pkg::t_out_word predict_contact(input ptc_pkg::t_in_word w,
                                                           input logic [15:0] tol);
        ptc_pkg::t_out_word r;
        longint      p[3], va[3], vb[3], vc[3], q[3], nrm[3], c[3];
        longint      ed[15], all[15], x[3], y[3];
        logic [63:0] m[3], mx, sum, len, tri_area, sub_area, thr;
        longint      acc, g;
        int          sn, s, rs;
        r = '0;
        p  = '{longint'(w.point_x), longint'(w.point_y), longint'(w.point_z)};
        va = '{longint'(w.vertex_a_x), longint'(w.vertex_a_y), longint'(w.vertex_a_z)};
        vb = '{longint'(w.vertex_b_x), longint'(w.vertex_b_y), longint'(w.vertex_b_z)};
        vc = '{longint'(w.vertex_c_x), longint'(w.vertex_c_y), longint'(w.vertex_c_z)};
        for (int i = 0; i < 15; i++) ed[i] = 0;
        for (int i = 0; i < 3; i++) begin
            ed[i] = vb[i] - va[i];
            ed[3 + i] = vc[i] - va[i];
        end
        sn = fit_shift_of(ed, 6);
        for (int i = 0; i < 3; i++) begin
            x[i] = floor_shr(ed[i], sn);
            y[i] = floor_shr(ed[3 + i], sn);
        end
        c[0] = x[1] * y[2] - x[2] * y[1];
        c[1] = x[2] * y[0] - x[0] * y[2];
        c[2] = x[0] * y[1] - x[1] * y[0];
        if (c[0] == 0 && c[1] == 0 && c[2] == 0) begin
            r.degenerate_flag = 1'b1;
            return r;
        end
        mx = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = mag64(c[i]);
            if (m[i] > mx) mx = m[i];
        end
        if (mx >= 64'd1073741824) begin
            rs = 0;
            while ((mx >> rs) >= 64'd1073741824) rs++;
            for (int i = 0; i < 3; i++) m[i] = m[i] >> rs;
        end else begin
            while (mx < 64'd536870912) begin
                mx = mx << 1;
                for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
            end
        end
        sum = 0;
        for (int i = 0; i < 3; i++) sum += m[i] * m[i];
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            nrm[i] = longint'(((m[i] << 30) + (len >> 1)) / len);
            if (c[i] < 0) nrm[i] = -nrm[i];
        end
        acc = 0;
        for (int i = 0; i < 3; i++) acc += floor_shr((p[i] - va[i]) * nrm[i], 2);
        g = round_shr(acc, 28);
        for (int i = 0; i < 3; i++) q[i] = p[i] - round_shr(g * round_shr(nrm[i], 2), 28);
        for (int i = 0; i < 3; i++) begin
            all[i] = vb[i] - va[i];
            all[3 + i] = vc[i] - va[i];
            all[6 + i] = va[i] - q[i];
            all[9 + i] = vb[i] - q[i];
            all[12 + i] = vc[i] - q[i];
        end
        s = fit_shift_of(all, 15);
        for (int i = 0; i < 15; i++) all[i] = floor_shr(all[i], s);
        tri_area = cross_norm('{all[0], all[1], all[2]}, '{all[3], all[4], all[5]});
        sub_area = cross_norm('{all[6], all[7], all[8]}, '{all[9], all[10], all[11]})
                 + cross_norm('{all[9], all[10], all[11]}, '{all[12], all[13], all[14]})
                 + cross_norm('{all[12], all[13], all[14]}, '{all[6], all[7], all[8]});
        thr = (64'(tol) << 17) >> (2 * s);
        r.normal_x    = nrm[0][31:0];
        r.normal_y    = nrm[1][31:0];
        r.normal_z    = nrm[2][31:0];
        r.gap_value   = 32'(sat_word(g));
        r.projected_x = 32'(sat_word(q[0]));
        r.projected_y = 32'(sat_word(q[1]));
        r.projected_z = 32'(sat_word(q[2]));
        r.inside_flag = g < -longint'(tol);
        r.in_area_flag = (sub_area <= tri_area) || (sub_area - tri_area <= thr);
        return r;
    endfunction

    assign o_pending = contact_q.size();

    always @(posedge i_clk) begin
        ptc_pkg::t_out_word exp_w;
        if (!i_rst_n) begin
            tol_reg <= ptc_pkg::TOL_RESET;
            o_fail_count <= 0;
            o_result_count <= 0;
            o_deg_count <= 0;
            o_area_count <= 0;
            o_inside_count <= 0;
        end else begin
            if (i_cfg_we) tol_reg <= i_cfg_data;
            if (i_in_valid && i_in_ready)
                contact_q = {contact_q, predict_contact(i_in_data, tol_reg)};
            if (i_out_valid && i_out_ready) begin
                o_result_count <= o_result_count + 1;
                if (contact_q.size() == 0) begin
                    if (o_fail_count < 10) $display("ERROR: result word with none expected");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_w = contact_q.pop_front();
                    o_deg_count <= o_deg_count + exp_w.degenerate_flag;
                    o_area_count <= o_area_count + exp_w.in_area_flag;
                    o_inside_count <= o_inside_count + exp_w.inside_flag;
                    if (i_out_data !== exp_w) begin
                        if (o_fail_count < 10) begin
                            $display("ERROR: mismatch exp n=%0d,%0d,%0d g=%0d q=%0d,%0d,%0d f=%b%b%b",
                                exp_w.normal_x, exp_w.normal_y, exp_w.normal_z,
                                exp_w.gap_value, exp_w.projected_x, exp_w.projected_y,
                                exp_w.projected_z, exp_w.inside_flag,
                                exp_w.in_area_flag, exp_w.degenerate_flag);
                            $display("       got n=%0d,%0d,%0d g=%0d q=%0d,%0d,%0d f=%b%b%b",
                                i_out_data.normal_x, i_out_data.normal_y,
                                i_out_data.normal_z, i_out_data.gap_value,
                                i_out_data.projected_x, i_out_data.projected_y,
                                i_out_data.projected_z, i_out_data.inside_flag,
                                i_out_data.in_area_flag, i_out_data.degenerate_flag);
                        end
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== tb/sv/tb.sv =====
// ---------------------------------------------------------------------------
// tb: stimulus and verdict for the point/triangle contact test
// Directed corner words, then random point/triangle pairs under several
// tolerance settings, with random gaps on both channels and one long stall.
// ---------------------------------------------------------------------------
module tb;

    localparam int N_RANDOM  = 1730;
    localparam int LATENCY   = 121;
    localparam int CYCLE_MAX = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [15:0] cfg_data;
    int          fail_count, pending, result_count, deg_count, area_count, inside_count;
    int          sent_count;
    int          cycle_count = 0;
    logic        hold_off;
    logic        sink_rand;

    ptc_in_if  in_ch();
    ptc_out_if out_ch();

    point_triangle_contact_test dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_ch.sink),
        .o_out     (out_ch.source),
        .i_cfg_we  (cfg_we),
        .i_cfg_data(cfg_data)
    );

    ptc_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_ch.valid),
        .i_in_ready    (in_ch.ready),
        .i_in_data     (in_ch.data),
        .i_out_valid   (out_ch.valid),
        .i_out_ready   (out_ch.ready),
        .i_out_data    (out_ch.data),
        .i_cfg_we      (cfg_we),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_result_count(result_count),
        .o_deg_count   (deg_count),
        .o_area_count  (area_count),
        .o_inside_count(inside_count)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic ptc_pkg::t_s32 coord(input int span);
        int r;
        r = $urandom_range(0, 15);
        if (r == 0) return ptc_pkg::t_s32'($urandom());
        if (r == 1) return ($urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000);
        return ptc_pkg::t_s32'($urandom_range(0, 2 * span) - span);
    endfunction

    // random triangle and point; some draws collapse C onto B or flatten the triangle in z
    function automatic ptc_pkg::t_in_word rand_word();
        ptc_pkg::t_in_word w;
        int       span, sel;
        sel = $urandom_range(0, 9);
        span = (sel < 6) ? 32'h0004_0000 : (sel < 9 ? 32'h0100_0000 : 32'h4000_0000);
        w.vertex_a_x = coord(span);
        w.vertex_a_y = coord(span);
        w.vertex_a_z = coord(span);
        w.vertex_b_x = coord(span);
        w.vertex_b_y = coord(span);
        w.vertex_b_z = coord(span);
        w.vertex_c_x = coord(span);
        w.vertex_c_y = coord(span);
        w.vertex_c_z = coord(span);
        w.point_x = coord(span);
        w.point_y = coord(span);
        w.point_z = coord(span);
        case ($urandom_range(0, 5))
            0: begin
                // collapse C onto the line through A and B
                w.vertex_c_x = w.vertex_b_x;
                w.vertex_c_y = w.vertex_b_y;
                w.vertex_c_z = w.vertex_b_z;
            end
            1: begin
                // flat triangle in z, point just above, below or on its plane
                w.vertex_b_z = w.vertex_a_z;
                w.vertex_c_z = w.vertex_a_z;
                w.point_z = w.vertex_a_z + $urandom_range(0, 8) - 4;
                w.point_x = (w.vertex_a_x >>> 1) + (w.vertex_b_x >>> 2) + (w.vertex_c_x >>> 2);
                w.point_y = (w.vertex_a_y >>> 1) + (w.vertex_b_y >>> 2) + (w.vertex_c_y >>> 2);
            end
            default: ;
        endcase
        return w;
    endfunction

    task automatic send_word(input ptc_pkg::t_in_word w);
        int g;
        g = gap_len();
        repeat (g) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= w;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sent_count++;
    endtask

    task automatic drain_and_write(input logic [15:0] tol);
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_data <= tol;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic directed_words();
        ptc_pkg::t_in_word w;
        // unit right triangle in the xy plane, point above, below, just below, outside the area, far away
        w = '0;
        w.vertex_b_x = 32'sh0001_0000;
        w.vertex_c_y = 32'sh0001_0000;
        w.point_x = 32'sh0000_4000;
        w.point_y = 32'sh0000_4000;
        w.point_z = 32'sh0000_8000;
        send_word(w);
        w.point_z = -32'sh0000_8000;
        send_word(w);
        w.point_z = -32'sh0000_0001;
        send_word(w);
        w.point_z = -32'sh0000_0002;
        send_word(w);
        w.point_x = 32'sh0003_0000;
        send_word(w);
        w.point_x = 32'sh7fff_ffff;
        w.point_y = 32'sh8000_0000;
        w.point_z = 32'sh8000_0000;
        send_word(w);
        // all vertices equal
        w = '0;
        w.point_z = 32'sh0001_0000;
        send_word(w);
        // collinear vertices
        w.vertex_b_x = 32'sh0001_0000;
        w.vertex_c_x = 32'sh0002_0000;
        send_word(w);
        // extreme spread triangle with saturating projection
        w = '0;
        w.vertex_a_x = 32'sh8000_0000;
        w.vertex_a_y = 32'sh8000_0000;
        w.vertex_a_z = 32'sh8000_0000;
        w.vertex_b_x = 32'sh7fff_ffff;
        w.vertex_b_y = 32'sh8000_0000;
        w.vertex_b_z = 32'sh7fff_ffff;
        w.vertex_c_x = 32'sh8000_0000;
        w.vertex_c_y = 32'sh7fff_ffff;
        w.vertex_c_z = 32'sh7fff_ffff;
        w.point_x = 32'sh7fff_ffff;
        w.point_y = 32'sh7fff_ffff;
        w.point_z = 32'sh8000_0000;
        send_word(w);
        w.point_z = 32'sh7fff_ffff;
        send_word(w);
        // very thin huge triangle that scales to nothing
        w = '0;
        w.vertex_a_x = 32'sh8000_0000;
        w.vertex_b_x = 32'sh7fff_ffff;
        w.vertex_c_x = 32'sh7fff_fffe;
        w.vertex_c_y = 32'sh0000_0001;
        send_word(w);
        // tiny triangle, all bits set and clear
        w = '1;
        w.vertex_b_x = 32'sh0000_0000;
        w.vertex_c_y = 32'sh0000_0000;
        send_word(w);
        // tilted triangle, point on its plane at a vertex
        w = '0;
        w.vertex_a_z = 32'sh0001_0000;
        w.vertex_b_x = 32'sh0001_0000;
        w.vertex_c_y = 32'sh0001_0000;
        w.point_z = 32'sh0001_0000;
        send_word(w);
        w.point_x = -32'sh0001_0000;
        w.point_y = -32'sh0001_0000;
        send_word(w);
    endtask

    // receiver: random stalls outside a window of result counts, plus one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sink_rand <= 1'b1;
        end else begin
            sink_rand <= ($urandom_range(0, 99) < 70) || (result_count > 1200 && result_count < 1400);
        end
    end

    initial begin
        hold_off = 1'b0;
        wait (sent_count > 300);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (400) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    always_comb out_ch.ready = sink_rand && !hold_off && i_rst_n;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_MAX) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        logic [15:0] tol_set[4];
        sent_count = 0;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        cfg_we = 1'b0;
        cfg_data = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        directed_words();
        tol_set = '{16'd0, 16'hffff, 16'd1, 16'd0};
        for (int ph = 0; ph < 4; ph++) begin
            drain_and_write(ph == 3 ? 16'($urandom_range(2, 65534)) : tol_set[ph]);
            if (ph == 1) directed_words();
            for (int n = 0; n < N_RANDOM / 4; n++) send_word(rand_word());
        end
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("Covered %0d words across 4 tolerance settings and reset value.", sent_count);
        $display("Degenerate %0d, in area %0d, inside %0d.", deg_count, area_count,
                 inside_count);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
